FILE: rtl/rte_pkg.sv
// route entry table shared types, opcodes and status codes
`default_nettype none
package rte_pkg;

    localparam int ADDR_W     = 32;
    localparam int PLEN_W     = 6;
    localparam int IF_W       = 8;
    localparam int KEY_W      = ADDR_W + PLEN_W;
    localparam int ROUTE_W    = ADDR_W + IF_W;
    localparam int OP_W       = 2;
    localparam int STATUS_W   = 2;
    localparam int COUNT_OUT_W = 5;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_UPDATE = 2'd1;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_DONE     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DUP      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd3;

    typedef logic [KEY_W-1:0]   t_key;
    typedef logic [ROUTE_W-1:0] t_route;

    typedef struct packed {
        logic [OP_W-1:0] op;
        t_key            key;
        t_route          route;
    } t_req;

    typedef struct packed {
        logic [STATUS_W-1:0]    status;
        logic [COUNT_OUT_W-1:0] entry_count;
    } t_rsp;

    typedef struct packed {
        logic hit;
        logic full;
    } t_match;

endpackage
`default_nettype wire

FILE: rtl/rte_match.sv
// parallel key comparators and lowest free slot pick
`default_nettype none
module rte_match
    import rte_pkg::*;
#(
    parameter int SLOTS = 16
) (
    input  var t_key             i_key,
    input  var t_key             i_slot_key [SLOTS],
    input  var logic [SLOTS-1:0] i_slot_valid,
    output var logic [SLOTS-1:0] o_hit_vec,
    output var logic [SLOTS-1:0] o_free_vec,
    output var t_match           o_flags
);

    logic [SLOTS-1:0] free_mask;

    always_comb begin
        for (int i = 0; i < SLOTS; i++) begin
            o_hit_vec[i] = i_slot_valid[i] && (i_slot_key[i] == i_key);
        end
    end

    // isolate lowest clear bit of the valid vector
    assign free_mask  = ~i_slot_valid;
    assign o_free_vec = free_mask & (~free_mask + {{(SLOTS-1){1'b0}}, 1'b1});

    assign o_flags.hit  = |o_hit_vec;
    assign o_flags.full = &i_slot_valid;

endmodule
`default_nettype wire

FILE: rtl/rte_table.sv
// route table storage, operation decode and entry count
`default_nettype none
module rte_table
    import rte_pkg::*;
#(
    parameter int SLOTS = 16
) (
    input  var logic i_clk,
    input  var logic i_rst_n,
    input  var logic i_en,
    input  var t_req i_req,
    output var t_rsp o_rsp
);

    localparam int CW = $clog2(SLOTS + 1);

    logic [SLOTS-1:0] r_valid;
    logic [SLOTS-1:0] n_valid;
    t_key             r_key   [SLOTS];
    t_route           r_route [SLOTS];
    logic [CW-1:0]    r_count;
    logic [CW-1:0]    n_count;

    logic [SLOTS-1:0] hit_vec;
    logic [SLOTS-1:0] free_vec;
    t_match           flags;
    logic             do_ins;
    logic             do_upd;
    logic             do_del;
    logic [STATUS_W-1:0] status;
    logic [SLOTS-1:0] key_wr;
    logic [SLOTS-1:0] route_wr;
    logic [CW+COUNT_OUT_W-1:0] count_ext;

    rte_match #(
        .SLOTS(SLOTS)
    ) u_match (
        .i_key        (i_req.key),
        .i_slot_key   (r_key),
        .i_slot_valid (r_valid),
        .o_hit_vec    (hit_vec),
        .o_free_vec   (free_vec),
        .o_flags      (flags)
    );

    always_comb begin
        do_ins = 1'b0;
        do_upd = 1'b0;
        do_del = 1'b0;
        status = ST_DONE;
        case (i_req.op)
            OP_INSERT: begin
                if (flags.hit) begin
                    status = ST_DUP;
                end else if (flags.full) begin
                    status = ST_FULL;
                end else begin
                    do_ins = 1'b1;
                end
            end
            OP_UPDATE: begin
                if (flags.hit) begin
                    do_upd = 1'b1;
                end else begin
                    status = ST_NOTFOUND;
                end
            end
            OP_DELETE: begin
                if (flags.hit) begin
                    do_del = 1'b1;
                end else begin
                    status = ST_NOTFOUND;
                end
            end
            default: begin
                status = ST_DONE;
            end
        endcase
    end

    assign key_wr   = do_ins ? free_vec : '0;
    assign route_wr = do_ins ? free_vec : (do_upd ? hit_vec : '0);
    assign n_valid  = (r_valid | key_wr) & ~(do_del ? hit_vec : '0);

    always_comb begin
        n_count = r_count;
        if (do_ins) begin
            n_count = r_count + {{(CW-1){1'b0}}, 1'b1};
        end else if (do_del) begin
            n_count = r_count - {{(CW-1){1'b0}}, 1'b1};
        end
    end

    assign count_ext         = {{COUNT_OUT_W{1'b0}}, n_count};
    assign o_rsp.status      = status;
    assign o_rsp.entry_count = count_ext[COUNT_OUT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_count <= '0;
        end else if (i_en) begin
            r_valid <= n_valid;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < SLOTS; i++) begin
            if (i_en && key_wr[i]) begin
                r_key[i] <= i_req.key;
            end
            if (i_en && route_wr[i]) begin
                r_route[i] <= i_req.route;
            end
        end
    end

    a_count_matches_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count == CW'($countones(r_valid)))
        else $error("entry count differs from valid slots");

    a_key_unique: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(hit_vec))
        else $error("key present in more than one slot");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && do_ins) |=> r_count == $past(r_count) + {{(CW-1){1'b0}}, 1'b1})
        else $error("insert did not add one entry");

    a_full_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && status == ST_FULL) |-> (&r_valid))
        else $error("full reported with a free slot");

    a_delete_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && do_del) |=> ((r_valid & $past(hit_vec)) == '0))
        else $error("deleted slot still valid");

endmodule
`default_nettype wire

FILE: rtl/route_entry_table.sv
// route entry table top level: input register, table, result register
//
//  beat      dir  handshake           payload
//  request   in   i_valid / o_ready   i_op i_dest_addr i_prefix_len i_gateway_addr i_out_if
//  result    out  o_valid / i_ready   o_status o_entry_count
//
// one request per cycle unless results stall; result register loads from input register
// lookup and free slot pick read the input register; the table writes as the result loads
// reset clears all valid bits and the count at once; no clearing pass
// a stalled result holds the input register, which then drops o_ready
`default_nettype none
module route_entry_table
    import rte_pkg::*;
#(
    parameter int TABLE_SLOTS = 16
) (
    input  var logic                   i_clk,
    input  var logic                   i_rst_n,
    input  var logic                   i_valid,
    output var logic                   o_ready,
    input  var logic [OP_W-1:0]        i_op,
    input  var logic [ADDR_W-1:0]      i_dest_addr,
    input  var logic [PLEN_W-1:0]      i_prefix_len,
    input  var logic [ADDR_W-1:0]      i_gateway_addr,
    input  var logic [IF_W-1:0]        i_out_if,
    output var logic                   o_valid,
    input  var logic                   i_ready,
    output var logic [STATUS_W-1:0]    o_status,
    output var logic [COUNT_OUT_W-1:0] o_entry_count
);

    logic r_in_valid;
    t_req r_req;
    logic r_out_valid;
    t_rsp r_rsp;
    t_rsp rsp;
    logic advance;
    logic accept;

    assign advance = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || advance;
    assign accept  = i_valid && o_ready;

    rte_table #(
        .SLOTS(TABLE_SLOTS)
    ) u_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (advance),
        .i_req   (r_req),
        .o_rsp   (rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req.op    <= i_op;
            r_req.key   <= {i_dest_addr, i_prefix_len};
            r_req.route <= {i_gateway_addr, i_out_if};
        end
        if (advance) begin
            r_rsp <= rsp;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_status      = r_rsp.status;
    assign o_entry_count = r_rsp.entry_count;

endmodule
`default_nettype wire

FILE: verif/route_entry_table_checker.sv
// route entry table checker: table prediction and result comparison
module route_entry_table_checker
    import rte_pkg::*;
#(
    parameter int TABLE_SLOTS = 16
) (
    input  var logic                   i_clk,
    input  var logic                   i_rst_n,
    input  var logic                   i_req_valid,
    input  var logic                   i_req_ready,
    input  var logic [OP_W-1:0]        i_op,
    input  var logic [ADDR_W-1:0]      i_dest_addr,
    input  var logic [PLEN_W-1:0]      i_prefix_len,
    input  var logic [ADDR_W-1:0]      i_gateway_addr,
    input  var logic [IF_W-1:0]        i_out_if,
    input  var logic                   i_rsp_valid,
    input  var logic                   i_rsp_ready,
    input  var logic [STATUS_W-1:0]    i_status,
    input  var logic [COUNT_OUT_W-1:0] i_entry_count,
    output var int                     o_fail_count,
    output var int                     o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic   slot_live [TABLE_SLOTS];
    t_key   slot_key  [TABLE_SLOTS];
    t_route slot_route[TABLE_SLOTS];
    int     live_count;
    t_rsp   route_rsp_q[$];
    int     fail_count;

    assign o_fail_count = fail_count;
    assign o_pending    = route_rsp_q.size();

    function automatic t_rsp apply_route_op(input logic [OP_W-1:0] op, input t_key key,
                                            input t_route route);
        t_rsp rsp;
        int   hit;
        int   free_slot;
        hit = -1;
        free_slot = -1;
        for (int s = TABLE_SLOTS - 1; s >= 0; s--) begin
            if (slot_live[s] && slot_key[s] == key) hit = s;
            if (!slot_live[s]) free_slot = s;
        end
        rsp.status = ST_DONE;
        case (op)
            OP_INSERT: begin
                if (hit >= 0) begin
                    rsp.status = ST_DUP;
                end else if (free_slot < 0) begin
                    rsp.status = ST_FULL;
                end else begin
                    slot_live[free_slot]  = 1'b1;
                    slot_key[free_slot]   = key;
                    slot_route[free_slot] = route;
                    live_count++;
                end
            end
            OP_UPDATE: begin
                if (hit < 0) rsp.status = ST_NOTFOUND;
                else slot_route[hit] = route;
            end
            OP_DELETE: begin
                if (hit < 0) begin
                    rsp.status = ST_NOTFOUND;
                end else begin
                    slot_live[hit] = 1'b0;
                    if (live_count > 0) live_count--;
                end
            end
            default: ;
        endcase
        rsp.entry_count = live_count[COUNT_OUT_W-1:0];
        return rsp;
    endfunction

    always @(posedge i_clk) begin
        t_rsp want;
        if (!i_rst_n) begin
            for (int s = 0; s < TABLE_SLOTS; s++) slot_live[s] = 1'b0;
            live_count = 0;
            route_rsp_q.delete();
        end else begin
            // results leave only after their request has been taken, so pop first
            if (i_rsp_valid && i_rsp_ready) begin
                if (route_rsp_q.size() == 0) begin
                    $error("result beat with no request outstanding: status %0d count %0d",
                           i_status, i_entry_count);
                    fail_count++;
                end else begin
                    want = route_rsp_q.pop_front();
                    if (i_status !== want.status) begin
                        $error("status mismatch: expected %0d, actual %0d",
                               want.status, i_status);
                        fail_count++;
                    end
                    if (i_entry_count !== want.entry_count) begin
                        $error("entry_count mismatch: expected %0d, actual %0d",
                               want.entry_count, i_entry_count);
                        fail_count++;
                    end
                end
            end
            if (i_req_valid && i_req_ready) begin
                route_rsp_q.push_back(apply_route_op(i_op, {i_dest_addr, i_prefix_len},
                                                     {i_gateway_addr, i_out_if}));
            end
        end
    end

    initial begin
        fail_count = 0;
        live_count = 0;
        for (int s = 0; s < TABLE_SLOTS; s++) begin
            slot_live[s]  = 1'b0;
            slot_key[s]   = '0;
            slot_route[s] = '0;
        end
    end

endmodule

FILE: verif/route_entry_table_tb.sv
// route entry table testbench top: clock, reset, request and result traffic, verdict
module route_entry_table_tb
    import rte_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int              SLOTS       = 16;
    localparam int              RAND_ITEMS  = 1725;
    localparam int              POOL_SIZE   = 24;
    localparam int              STALL_LIMIT = 5000;
    localparam logic [OP_W-1:0] OP_UNUSED   = 2'd3;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_valid;
    logic                   o_ready;
    logic [OP_W-1:0]        i_op;
    logic [ADDR_W-1:0]      i_dest_addr;
    logic [PLEN_W-1:0]      i_prefix_len;
    logic [ADDR_W-1:0]      i_gateway_addr;
    logic [IF_W-1:0]        i_out_if;
    logic                   o_valid;
    logic                   i_ready;
    logic [STATUS_W-1:0]    o_status;
    logic [COUNT_OUT_W-1:0] o_entry_count;

    int   fail_count;
    int   pending;
    int   stall_cycles;
    logic draining;
    logic quiet;

    route_entry_table #(.TABLE_SLOTS(SLOTS)) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_op          (i_op),
        .i_dest_addr   (i_dest_addr),
        .i_prefix_len  (i_prefix_len),
        .i_gateway_addr(i_gateway_addr),
        .i_out_if      (i_out_if),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_status      (o_status),
        .o_entry_count (o_entry_count)
    );

    route_entry_table_checker #(.TABLE_SLOTS(SLOTS)) u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_valid   (i_valid),
        .i_req_ready   (o_ready),
        .i_op          (i_op),
        .i_dest_addr   (i_dest_addr),
        .i_prefix_len  (i_prefix_len),
        .i_gateway_addr(i_gateway_addr),
        .i_out_if      (i_out_if),
        .i_rsp_valid   (o_valid),
        .i_rsp_ready   (i_ready),
        .i_status      (o_status),
        .i_entry_count (o_entry_count),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [PLEN_W-1:0] rand_plen();
        if ($urandom_range(0, 3) == 0) return PLEN_W'($urandom_range(33, 63));
        return PLEN_W'($urandom_range(0, 32));
    endfunction

    task automatic send_route_op(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] dest,
                                 input logic [PLEN_W-1:0] plen,
                                 input logic [ADDR_W-1:0] gw, input logic [IF_W-1:0] oif);
        int gap;
        gap = quiet ? 0 : idle_len();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_op           <= op;
        i_dest_addr    <= dest;
        i_prefix_len   <= plen;
        i_gateway_addr <= gw;
        i_out_if       <= oif;
        i_valid        <= 1'b1;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
    endtask

    // result side back-pressure
    initial begin
        int hold;
        hold = 0;
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (draining || quiet) begin
                i_ready <= 1'b1;
            end else if (hold > 0) begin
                hold--;
            end else if (i_ready) begin
                i_ready <= 1'b0;
                hold = idle_len();
            end else begin
                i_ready <= 1'b1;
                hold = $urandom_range(0, 20);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        logic [ADDR_W-1:0] pool_dest[POOL_SIZE];
        logic [PLEN_W-1:0] pool_plen[POOL_SIZE];
        logic [ADDR_W-1:0] dest;
        logic [PLEN_W-1:0] plen;
        logic [OP_W-1:0]   op;
        int                pick;
        int                r;
        int                segment;

        stall_cycles   = 0;
        draining       = 1'b0;
        quiet          = 1'b0;
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_op           = OP_INSERT;
        i_dest_addr    = '0;
        i_prefix_len   = '0;
        i_gateway_addr = '0;
        i_out_if       = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: extremes, every outcome, prefix above 32, full table
        send_route_op(OP_INSERT, '0, '0, '0, '0);
        send_route_op(OP_INSERT, '1, '1, '1, '1);
        send_route_op(OP_INSERT, '0, '0, 32'h1234_5678, 8'h9a);
        send_route_op(OP_UPDATE, '1, '1, 32'h5a5a_a5a5, 8'h3c);
        send_route_op(OP_UPDATE, '0, 6'd33, 32'h0bad_f00d, 8'h01);
        send_route_op(OP_DELETE, '0, 6'd33, '0, '0);
        send_route_op(OP_UNUSED, 32'hc0a8_0000, 6'd16, 32'hc0a8_0001, 8'h02);
        send_route_op(OP_INSERT, '0, 6'd33, 32'h0a00_0001, 8'h10);
        for (int k = 0; k < SLOTS - 3; k++) begin
            send_route_op(OP_INSERT, 32'h0a00_0000 + (k << 8), 6'd24, $urandom, 8'(k));
        end
        send_route_op(OP_INSERT, 32'hac10_0000, 6'd12, 32'hac10_0001, 8'h20);
        send_route_op(OP_INSERT, '0, '0, 32'hffff_0000, 8'h77);
        send_route_op(OP_UPDATE, '0, '0, 32'h0000_ffff, 8'h88);
        send_route_op(OP_DELETE, '1, '1, '0, '0);
        send_route_op(OP_DELETE, '1, '1, '0, '0);
        send_route_op(OP_UNUSED, '1, '1, '1, '1);

        // random: keys from a small pool so hits, duplicates and full tables recur
        for (int p = 0; p < POOL_SIZE; p += 2) begin
            pool_dest[p]     = $urandom;
            pool_plen[p]     = rand_plen();
            pool_dest[p + 1] = ($urandom_range(0, 1) == 0) ? pool_dest[p] :
                               pool_dest[p] ^ (32'd1 << $urandom_range(0, 31));
            pool_plen[p + 1] = (pool_dest[p + 1] == pool_dest[p]) ?
                               pool_plen[p] ^ 6'(1 << $urandom_range(0, 5)) : pool_plen[p];
        end
        for (int n = 0; n < RAND_ITEMS; n++) begin
            segment = n / 150;
            quiet = (segment % 4 == 3);
            if (n % 200 == 199) begin
                pick = $urandom_range(0, POOL_SIZE - 1);
                pool_dest[pick] = $urandom;
                pool_plen[pick] = rand_plen();
            end
            pick = $urandom_range(0, POOL_SIZE - 1);
            dest = pool_dest[pick];
            plen = pool_plen[pick];
            if ($urandom_range(0, 99) < 5) begin
                dest = $urandom;
                plen = PLEN_W'($urandom_range(0, 63));
            end
            r = $urandom_range(0, 99);
            if (segment % 2 == 0) begin
                op = (r < 60) ? OP_INSERT : (r < 80) ? OP_UPDATE : (r < 95) ? OP_DELETE :
                     OP_UNUSED;
            end else begin
                op = (r < 25) ? OP_INSERT : (r < 45) ? OP_UPDATE : (r < 95) ? OP_DELETE :
                     OP_UNUSED;
            end
            send_route_op(op, dest, plen, $urandom, IF_W'($urandom_range(0, 255)));
        end
        i_valid  <= 1'b0;
        quiet    = 1'b0;
        draining = 1'b1;

        while (pending != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
